[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked assertions with an active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/wrm_pkg.sv]
// ---------------------------------------------------------------------------
// wrm_pkg
// sizes, character codes and controller/datapath bundles of the matcher
// ---------------------------------------------------------------------------
package wrm_pkg;

	localparam int MAX_PAT = 32;
	localparam int ROW_W   = MAX_PAT + 1;
	localparam int LEN_W   = $clog2(MAX_PAT + 1);
	localparam int ADDR_W  = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;

	localparam logic [7:0] CH_STAR = 8'd42;
	localparam logic [7:0] CH_DOT  = 8'd46;

	localparam logic FUNC_PAT  = 1'b0;
	localparam logic FUNC_SUBJ = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load_pat;
		logic load_subj;
		logic step;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_step;
		logic len_zero;
	} status_t;

endpackage

[rtl/core/wrm_ctrl.sv]
// ---------------------------------------------------------------------------
// wrm_ctrl
// sequencer: takes an item, walks the pattern positions, hands off the result
// ---------------------------------------------------------------------------
module wrm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_func,
	output logic             out_valid,
	input  logic             out_ready,
	output wrm_pkg::cmd_t    cmd,
	input  wrm_pkg::status_t stat
);
	import wrm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_STEP = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd.load_pat  = 1'b0;
		cmd.load_subj = 1'b0;
		cmd.step      = 1'b0;
		cmd.emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_func == FUNC_PAT) begin
						cmd.load_pat = 1'b1;
						state_d      = ST_EMIT;
					end else begin
						cmd.load_subj = 1'b1;
						state_d       = stat.len_zero ? ST_EMIT : ST_STEP;
					end
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (stat.last_step)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/wrm_dpath.sv]
// ---------------------------------------------------------------------------
// wrm_dpath
// pattern memory, match rows and the one-position-per-cycle row update
// ---------------------------------------------------------------------------
module wrm_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  wrm_pkg::cmd_t    cmd,
	output wrm_pkg::status_t stat,
	input  logic [7:0]       in_ch,
	input  logic             in_first,
	output logic             res_match,
	output logic             res_overflow
);
	import wrm_pkg::*;

	// pattern memory, one write and one registered read per cycle
	logic [7:0]        mem [MAX_PAT];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] raddr;

	// architectural state
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [ROW_W-1:0] erow_q;
	logic [ROW_W-1:0] crow_q;
	logic             es_l_q;   // empty row bit at the pattern end
	logic             es_l1_q;  // empty row bit one before the end

	// per-subject scratch
	logic [ROW_W-1:0] csh_q;
	logic [ROW_W-1:0] nrow_q;
	logic             n1_q, n2_q;
	logic [7:0]       prev_q;
	logic [7:0]       ch_q;
	logic [LEN_W-1:0] idx_q;
	logic             m_q;
	logic             out_m_q, out_ovf_q;

	// pattern load path
	logic [LEN_W-1:0] len_base, len_inc;
	logic             ovf_base, es_l_base, es_l1_base;
	logic [ROW_W-1:0] erow_base, erow_new;
	logic             pat_full, e_bit;

	// subject step path
	logic             hit_p, hit_prev, is_star, s_bit;
	logic [ROW_W-1:0] nrow_next;

	assign len_base   = in_first ? '0 : len_q;
	assign ovf_base   = in_first ? 1'b0 : ovf_q;
	assign erow_base  = in_first ? ROW_W'(1) : erow_q;
	assign es_l_base  = in_first ? 1'b1 : es_l_q;
	assign es_l1_base = in_first ? 1'b0 : es_l1_q;
	assign pat_full   = (len_base == LEN_W'(MAX_PAT));
	assign len_inc    = LEN_W'(len_base + 1'b1);
	assign e_bit      = (in_ch == CH_STAR) && (len_base != '0) && es_l1_base;

	always_comb begin
		for (int k = 0; k < ROW_W; k++)
			erow_new[k] = (LEN_W'(k) == len_inc) ? e_bit : erow_base[k];
	end

	assign hit_p    = (rdata_q == ch_q) || (rdata_q == CH_DOT);
	assign hit_prev = (prev_q == ch_q) || (prev_q == CH_DOT);
	assign is_star  = (rdata_q == CH_STAR);

	// star: zero copies (two back) or one more copy of the element before it
	always_comb begin
		if (is_star)
			s_bit = (idx_q > LEN_W'(1)) &&
				(n2_q || ((csh_q[0] || csh_q[1]) && hit_prev));
		else
			s_bit = csh_q[0] && hit_p;
	end

	always_comb begin
		for (int k = 0; k < ROW_W; k++)
			nrow_next[k] = (LEN_W'(k) == idx_q) ? s_bit : nrow_q[k];
	end

	assign raddr          = cmd.step ? idx_q[ADDR_W-1:0] : '0;
	assign stat.last_step = (idx_q == len_q);
	assign stat.len_zero  = (len_q == '0);
	assign res_match      = out_m_q;
	assign res_overflow   = out_ovf_q;

	always_ff @(posedge clk) begin
		if (cmd.load_pat && !pat_full)
			mem[len_base[ADDR_W-1:0]] <= in_ch;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			erow_q  <= ROW_W'(1);
			crow_q  <= ROW_W'(1);
			es_l_q  <= 1'b1;
			es_l1_q <= 1'b0;
		end else if (cmd.load_pat) begin
			if (pat_full) begin
				len_q   <= len_base;
				ovf_q   <= 1'b1;
				erow_q  <= erow_base;
				crow_q  <= erow_base;
				es_l_q  <= es_l_base;
				es_l1_q <= es_l1_base;
			end else begin
				len_q   <= len_inc;
				ovf_q   <= ovf_base;
				erow_q  <= erow_new;
				crow_q  <= erow_new;
				es_l_q  <= e_bit;
				es_l1_q <= es_l_base;
			end
		end else if (cmd.load_subj && stat.len_zero) begin
			crow_q <= '0;
		end else if (cmd.step && stat.last_step) begin
			crow_q <= nrow_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pat) begin
			m_q <= pat_full ? es_l_base : e_bit;
		end else if (cmd.load_subj) begin
			csh_q  <= in_first ? erow_q : crow_q;
			nrow_q <= '0;
			n1_q   <= 1'b0;
			n2_q   <= 1'b0;
			idx_q  <= LEN_W'(1);
			ch_q   <= in_ch;
			m_q    <= 1'b0;
		end else if (cmd.step) begin
			nrow_q <= nrow_next;
			n2_q   <= n1_q;
			n1_q   <= s_bit;
			prev_q <= rdata_q;
			csh_q  <= csh_q >> 1;
			idx_q  <= LEN_W'(idx_q + 1'b1);
			m_q    <= s_bit;
		end
		if (cmd.emit) begin
			out_m_q   <= m_q;
			out_ovf_q <= ovf_q;
		end
	end

endmodule

[rtl/core/wildcard_regex_matcher_unit.sv]
// ---------------------------------------------------------------------------
// wildcard_regex_matcher_unit
// whole-string matcher for patterns with '.' and '*'
// ---------------------------------------------------------------------------
// Pattern bytes are loaded first (tuser = 0), then subject bytes are streamed
// (tuser = 1); tdata bit 8 set starts a new pattern or a new empty subject
// before the byte is taken. Every item returns one result item telling
// whether the subject so far matches the whole pattern, plus a sticky
// overflow bit once the pattern grew past 32 bytes (extra bytes are dropped).
// A subject item rebuilds the match row one pattern position per cycle,
// reading one byte per cycle from the single read port of the pattern
// memory. One item is in flight at a time; a finished result sits in an
// output register, so the next item is taken while it waits. There is no
// clearing pass after reset.
module wildcard_regex_matcher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] ch, [8] first, rest zero
	input  logic        s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [0] match, [1] overflow, rest zero
);
	import wrm_pkg::*;

	cmd_t    cmd;
	status_t stat;
	logic    res_match, res_overflow;

	// sequencer: one-hot idle / step / emit
	wrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// pattern memory, empty-subject row and current row
	wrm_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_ch        (s_axis_tdata[7:0]),
		.in_first     (s_axis_tdata[8]),
		.res_match    (res_match),
		.res_overflow (res_overflow)
	);

	// result item, upper bits tied off
	assign m_axis_tdata = {6'd0, res_overflow, res_match};

endmodule

[rtl/core/wrm_chk.sv]
// ---------------------------------------------------------------------------
// wrm_chk
// port-level checks on the matcher, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wrm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	// a stalled result item stays offered
	`AST_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// a stalled result item keeps its bits
	`AST_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

	// an accepted item keeps the block busy in the next cycle
	`AST_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a fresh result only appears after the block was busy
	`AST_SAME(a_result_from_work, clk, arst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind wildcard_regex_matcher_unit wrm_chk u_wrm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[tb/wildcard_regex_matcher_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_regex_matcher_unit_test
// self-checking bench for the dot/star whole-string matcher
// ---------------------------------------------------------------------------
// Loads patterns and streams subject bytes over the input stream. A
// scoreboard keeps its own copy of the pattern and the match rows, works out
// the match and overflow bits for every accepted item, and compares each
// result item in order. A directed opening covers the corner cases, then
// random patterns with random subjects follow, mixed with noise. Both sides
// idle at random, with one stretch held busy.
// ---------------------------------------------------------------------------
module wildcard_regex_matcher_unit_test;
	import wrm_pkg::*;

	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_C = 8'h63;
	localparam logic [7:0] CH_X = 8'h78;
	localparam int ITEM_TARGET = 450;
	localparam int SETTLE_CYCLES = 2 * MAX_PAT + 8;

	typedef struct {
		logic match;
		logic overflow;
	} match_verdict_t;

	// tracks the matcher state and the results still owed
	class match_scoreboard;
		logic [7:0]       pat [MAX_PAT];
		int               pat_len;
		logic [ROW_W-1:0] empty_row;
		logic [ROW_W-1:0] cur_row;
		logic             ovf;
		match_verdict_t   verdict_q [$];
		int               fails;

		function new();
			foreach (pat[i]) pat[i] = 8'd0;
			pat_len   = 0;
			empty_row = ROW_W'(1);
			cur_row   = ROW_W'(1);
			ovf       = 1'b0;
			fails     = 0;
		endfunction

		function logic hits(logic [7:0] p, logic [7:0] c);
			return (p == c) || (p == CH_DOT);
		endfunction

		// next row of the match table for one subject byte
		function logic [ROW_W-1:0] advance_row(logic [7:0] c);
			logic [ROW_W-1:0] nxt;
			nxt = '0;
			for (int j = 1; j <= pat_len; j++) begin
				if (pat[j-1] == CH_STAR) begin
					if (j > 1)
						nxt[j] = nxt[j-2] ||
							((cur_row[j-1] || cur_row[j]) && hits(pat[j-2], c));
				end else begin
					nxt[j] = cur_row[j-1] && hits(pat[j-1], c);
				end
			end
			return nxt;
		endfunction

		function void note_item(logic func, logic [7:0] ch, logic first);
			match_verdict_t v;
			if (func == FUNC_PAT) begin
				if (first) begin
					pat_len   = 0;
					ovf       = 1'b0;
					empty_row = ROW_W'(1);
				end
				if (pat_len >= MAX_PAT) begin
					ovf = 1'b1;
				end else begin
					pat[pat_len] = ch;
					pat_len++;
					empty_row[pat_len] = (ch == CH_STAR && pat_len >= 2) ?
						empty_row[pat_len-2] : 1'b0;
				end
				cur_row = empty_row;
				v.match = empty_row[pat_len];
			end else begin
				if (first)
					cur_row = empty_row;
				cur_row = advance_row(ch);
				v.match = cur_row[pat_len];
			end
			v.overflow = ovf;
			verdict_q.push_back(v);
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			fails++;
		endtask

		task check_result(logic [7:0] tdata);
			match_verdict_t v;
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result item %02h", tdata));
			end else begin
				v = verdict_q.pop_front();
				if (tdata[0] !== v.match)
					report_mismatch($sformatf("match got %b want %b", tdata[0], v.match));
				if (tdata[1] !== v.overflow)
					report_mismatch($sformatf("overflow got %b want %b",
						tdata[1], v.overflow));
			end
		endtask

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [7:0] ch, [8] first, rest zero
	logic        s_axis_tuser;   // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;   // [0] match, [1] overflow, rest zero

	match_scoreboard sb = new();
	bit busy_stretch = 1'b0;   // no idling on either side while set
	int items_sent = 0;

	wildcard_regex_matcher_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stalls about a quarter of the time, never during the busy stretch
	always @(posedge clk) begin
		m_axis_tready <= busy_stretch ? 1'b1 : ($urandom_range(0, 99) >= 24);
	end

	// accepted input items feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
	end

	// accepted result items are checked in order
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// offer one item, with random idle cycles ahead of it
	task automatic send_item(logic func, logic [7:0] ch, logic first);
		while (!busy_stretch && $urandom_range(0, 99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, first, ch};
		s_axis_tuser  <= func;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// hold off the sender until every owed result is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// mostly a small alphabet so that matches actually happen
	function automatic logic [7:0] pick_char(bit for_pattern);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 8'($urandom_range(0, 255));
		if (for_pattern) begin
			if (r < 40) return CH_A;
			if (r < 60) return CH_B;
			if (r < 78) return CH_DOT;
			return CH_STAR;
		end
		if (r < 50) return CH_A;
		if (r < 80) return CH_B;
		return CH_C;
	endfunction

	initial begin
		int pat_n;
		int subj_n;
		int subj_len;
		int round;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_PAT;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// subject with no pattern loaded, continued then restarted
		send_item(FUNC_SUBJ, CH_A, 1'b0);
		send_item(FUNC_SUBJ, 8'hff, 1'b1);
		// star as the first pattern element
		send_item(FUNC_PAT, CH_STAR, 1'b1);
		send_item(FUNC_SUBJ, CH_A, 1'b1);
		// a*b
		send_item(FUNC_PAT, CH_A, 1'b1);
		send_item(FUNC_PAT, CH_STAR, 1'b0);
		send_item(FUNC_PAT, CH_B, 1'b0);
		send_item(FUNC_SUBJ, CH_B, 1'b1);
		send_item(FUNC_SUBJ, CH_A, 1'b1);
		send_item(FUNC_SUBJ, CH_A, 1'b0);
		send_item(FUNC_SUBJ, CH_B, 1'b0);
		// pattern byte lands mid-subject, then the subject goes on from empty
		send_item(FUNC_SUBJ, CH_A, 1'b1);
		send_item(FUNC_PAT, CH_DOT, 1'b0);
		send_item(FUNC_SUBJ, CH_B, 1'b0);
		send_item(FUNC_SUBJ, CH_X, 1'b0);
		// star after star repeats a literal star
		send_item(FUNC_PAT, CH_A, 1'b1);
		send_item(FUNC_PAT, CH_STAR, 1'b0);
		send_item(FUNC_PAT, CH_STAR, 1'b0);
		send_item(FUNC_SUBJ, CH_STAR, 1'b1);
		send_item(FUNC_SUBJ, CH_A, 1'b1);
		send_item(FUNC_SUBJ, CH_STAR, 1'b0);
		// dot-star against the byte extremes
		send_item(FUNC_PAT, CH_DOT, 1'b1);
		send_item(FUNC_PAT, CH_STAR, 1'b0);
		send_item(FUNC_SUBJ, 8'h00, 1'b1);
		send_item(FUNC_SUBJ, 8'hff, 1'b0);
		wait_drained();

		round = 0;
		while (items_sent < ITEM_TARGET) begin
			busy_stretch = (items_sent >= 200 && items_sent < 300);
			if ($urandom_range(0, 99) < 85) begin
				// well-formed: a fresh pattern, then a few subjects
				pat_n = ($urandom_range(0, 11) == 0) ?
					$urandom_range(MAX_PAT - 4, MAX_PAT + 4) : $urandom_range(1, 6);
				for (int i = 0; i < pat_n; i++)
					send_item(FUNC_PAT, pick_char(1'b1), i == 0);
				subj_n = $urandom_range(1, 4);
				for (int s = 0; s < subj_n; s++) begin
					subj_len = (pat_n > 8) ? $urandom_range(1, 3) : $urandom_range(1, 10);
					for (int i = 0; i < subj_len; i++)
						send_item(FUNC_SUBJ, pick_char(1'b0), i == 0);
				end
			end else begin
				// noise: any field values
				repeat ($urandom_range(1, 4))
					send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end
			round++;
			if (round % 10 == 0)
				wait_drained();
		end
		busy_stretch = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
